>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL modules of the fixed-point ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define FALU_ASSERT_IMP(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("fixed-point ALU check failed");

// Next-cycle implication, checked outside reset.
`define FALU_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("fixed-point ALU check failed");

`else

`define FALU_ASSERT_IMP(label, clock, reset, ante, cons)
`define FALU_ASSERT_NEXT(label, clock, reset, ante, cons)

`endif

`endif

>>> rtl/core/falu_pkg.sv
// Types and constants of the Q24.8 fixed-point ALU.
`default_nettype none

package falu_pkg;

  localparam int WORD_BITS = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_t;

  typedef struct packed {
    logic [3:0]                  req_type;
    logic signed [WORD_BITS-1:0] operand_a;
    logic signed [WORD_BITS-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] value;
    logic                        a_less;
    logic                        a_equal;
    logic                        a_greater;
    logic                        overflow;
    logic                        div_zero;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/fixed_point_alu_q24_8.sv
// Pipelined signed fixed-point ALU: add, sub, mul, div, min, max, inc, dec, conversions.
//
//  channel | signals                           | beat
//  --------+-----------------------------------+---------------------------------
//  request | in_valid, in_ready, in_data       | opcode and two raw operands
//  result  | out_valid, out_ready, out_data    | value, compare flags, ovf, div0
//
// One beat enters per cycle while the skid register is empty. The pipeline depth is set
// by the restoring divider (one quotient bit per stage); the multiplier uses four of
// those stages: operand magnitudes, half-width partial products, their sum, sign fix.
// A consumer stall sends the beat leaving the last stage to the skid register,
// and every stage holds until that register drains. Reset clears valid bits only.
`default_nettype none

`include "assert_macros.svh"

module fixed_point_alu_q24_8 #(
  parameter int FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  falu_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output falu_pkg::rsp_t out_data
);
  import falu_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int H      = W / 2;
  localparam int NB     = W + FRAC_BITS;
  localparam int DEPTH  = NB + 2;
  localparam int MUL_ST = 5;
  localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic signed [W-1:0] value;
    logic                lt;
    logic                eq;
    logic                gt;
    logic                ovf;
    logic                dz;
    logic                neg;
  } stage_t;

  typedef struct packed {
    logic [W-1:0]  dvs;
    logic [W-1:0]  rem;
    logic [NB-1:0] nq;
  } quo_t;

  typedef struct packed {
    logic [2*H-1:0] ll;
    logic [2*H-1:0] lh;
    logic [2*H-1:0] hl;
    logic [2*H-1:0] hh;
  } pp_t;

  stage_t         cm      [1:DEPTH];
  stage_t         cm_next [1:DEPTH];
  stage_t         cm_head;
  quo_t           dv      [1:NB+1];
  quo_t           dv_next [1:NB+1];
  logic [W-1:0]   mag_a;
  logic [W-1:0]   mag_b;
  logic [W-1:0]   mag_a_next;
  logic [W-1:0]   mag_b_next;
  pp_t            pp;
  logic [2*W-1:0] prod;
  logic [2*W-1:0] sprod;
  logic           adv;
  logic           skid_valid;
  rsp_t           skid_data;
  rsp_t           fin;

  // One restoring step: shift in the next numerator bit, subtract when it fits.
  function automatic quo_t div_step(quo_t s);
    logic [W:0] trial;
    quo_t       r;
    trial = {s.rem, s.nq[NB-1]};
    r     = s;
    r.nq  = {s.nq[NB-2:0], 1'b0};
    if (trial >= {1'b0, s.dvs}) begin
      r.rem   = W'(trial - {1'b0, s.dvs});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = trial[W-1:0];
    end
    return r;
  endfunction

  assign adv      = !skid_valid;
  assign in_ready = adv;

  // Stage one: compare, the simple operations, operand magnitudes.
  always_comb begin
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
    logic [W-1:0]        sum;
    logic [W-1:0]        dif;
    logic [W-1:0]        inc;
    logic [W-1:0]        dec;
    logic [FRAC_BITS:0]  top;
    stage_t              s;
    a   = in_data.operand_a;
    b   = in_data.operand_b;
    sum = a + b;
    dif = a - b;
    inc = a + W'(1);
    dec = a - W'(1);
    top = a[W-1 -: FRAC_BITS+1];

    s       = '0;
    s.valid = in_valid;
    s.op    = op_t'(in_data.req_type);
    s.lt    = a < b;
    s.eq    = a == b;
    s.gt    = a > b;
    s.neg   = a[W-1] ^ b[W-1];
    unique case (s.op)
      OP_ADD: begin
        s.value = sum;
        s.ovf   = (a[W-1] == b[W-1]) && (sum[W-1] != a[W-1]);
      end
      OP_SUB: begin
        s.value = dif;
        s.ovf   = (a[W-1] != b[W-1]) && (dif[W-1] != a[W-1]);
      end
      OP_INC: begin
        s.value = inc;
        s.ovf   = !a[W-1] && inc[W-1];
      end
      OP_DEC: begin
        s.value = dec;
        s.ovf   = a[W-1] && !dec[W-1];
      end
      OP_MIN:      s.value = s.lt ? a : b;
      OP_MAX:      s.value = s.gt ? a : b;
      OP_TO_INT:   s.value = a >>> FRAC_BITS;
      OP_FROM_INT: begin
        s.value = a << FRAC_BITS;
        s.ovf   = !((&top) || !(|top));
      end
      OP_DIV:      s.dz = (b == '0);
      OP_MUL:      s.value = '0;
      default:     s.value = '0;
    endcase
    cm_head = s;

    mag_a_next = a[W-1] ? (~a + W'(1)) : a;
    mag_b_next = b[W-1] ? (~b + W'(1)) : b;
  end

  // Carry the common line forward; merge mul and div results where they finish.
  always_comb begin
    logic [W-FRAC_BITS:0] mtop;
    logic [W-1:0]         qlo;
    cm_next[1] = cm_head;
    for (int k = 2; k <= DEPTH; k++) begin
      cm_next[k] = cm[k-1];
    end

    mtop = sprod[2*W-1 : FRAC_BITS+W-1];
    if (cm[MUL_ST-1].op == OP_MUL) begin
      cm_next[MUL_ST].value = sprod[FRAC_BITS +: W];
      cm_next[MUL_ST].ovf   = !((&mtop) || !(|mtop));
    end

    qlo = dv[NB+1].nq[W-1:0];
    if (cm[DEPTH-1].op == OP_DIV && !cm[DEPTH-1].dz) begin
      cm_next[DEPTH].value = cm[DEPTH-1].neg ? (~qlo + W'(1)) : qlo;
      cm_next[DEPTH].ovf   = (|dv[NB+1].nq[NB-1:W])
                             || (cm[DEPTH-1].neg ? (qlo > MIN_MAG) : qlo[W-1]);
    end
  end

  always_comb begin
    dv_next[1].dvs = mag_b_next;
    dv_next[1].rem = '0;
    dv_next[1].nq  = {mag_a_next, {FRAC_BITS{1'b0}}};
    for (int k = 1; k <= NB; k++) begin
      dv_next[k+1] = div_step(dv[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= DEPTH; k++) begin
        cm[k].valid <= 1'b0;
      end
    end else if (adv) begin
      cm <= cm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv    <= dv_next;
      mag_a <= mag_a_next;
      mag_b <= mag_b_next;
      pp.ll <= mag_a[H-1:0] * mag_b[H-1:0];
      pp.lh <= mag_a[H-1:0] * mag_b[W-1:H];
      pp.hl <= mag_a[W-1:H] * mag_b[H-1:0];
      pp.hh <= mag_a[W-1:H] * mag_b[W-1:H];
      prod  <= {pp.hh, pp.ll}
               + ((2*W)'(pp.lh) << H)
               + ((2*W)'(pp.hl) << H);
      sprod <= cm[3].neg ? (~prod + (2*W)'(1)) : prod;
    end
  end

  assign fin = '{value:     cm[DEPTH].value,
                 a_less:    cm[DEPTH].lt,
                 a_equal:   cm[DEPTH].eq,
                 a_greater: cm[DEPTH].gt,
                 overflow:  cm[DEPTH].ovf,
                 div_zero:  cm[DEPTH].dz};

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_ready) begin
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (cm[DEPTH].valid) begin
        if (!out_valid || out_ready) begin
          out_data  <= fin;
          out_valid <= 1'b1;
        end else begin
          skid_data  <= fin;
          skid_valid <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FALU_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `FALU_ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !out_ready, skid_valid)
  `FALU_ASSERT_IMP(a_cmp_onehot, clk, rst, out_valid,
                   $onehot({out_data.a_less, out_data.a_equal, out_data.a_greater}))
  `FALU_ASSERT_IMP(a_div_zero_clean, clk, rst, out_valid && out_data.div_zero,
                   (out_data.value == '0) && !out_data.overflow)

endmodule

`default_nettype wire
